// ===== rtl/core/wlm_pkg.sv =====
// Package for the window local-maximum core.
// Holds the sample type, default window size, register map and cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package wlm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WINDOW_SIZE_DEF = 3;
  localparam int STRIP_IN = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_IGNORE    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic clear;
  } cell_ctrl_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage

// ===== rtl/core/wlm_cell.sv =====
// One stored strip of the sliding window.
// Shows its strip (or the ignore value at line start) and loads its neighbor's strip.
// Depends on wlm_pkg.
`timescale 1ns / 1ps

module wlm_cell #(
  parameter int WINDOW_SIZE = wlm_pkg::WINDOW_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wlm_pkg::cell_ctrl_t  ctrl,
  input  wlm_pkg::sample_t     ignore_value,
  input  wlm_pkg::sample_t     strip_in  [WINDOW_SIZE],
  output wlm_pkg::sample_t     strip_out [WINDOW_SIZE]
);
  import wlm_pkg::*;

  sample_t strip_r [WINDOW_SIZE];

  always_comb begin
    for (int p = 0; p < WINDOW_SIZE; p++) begin
      strip_out[p] = ctrl.clear ? ignore_value : strip_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < WINDOW_SIZE; p++) begin
        strip_r[p] <= SAMPLE_MIN;
      end
    end else if (ctrl.load) begin
      for (int p = 0; p < WINDOW_SIZE; p++) begin
        strip_r[p] <= strip_in[p];
      end
    end
  end

endmodule

// ===== rtl/core/wlm_peak.sv =====
// Local-maximum test over the full window.
// The centre passes when it is valid and no valid sample beats it in scan order.
// Depends on wlm_pkg.
`timescale 1ns / 1ps

module wlm_peak #(
  parameter int WINDOW_SIZE = wlm_pkg::WINDOW_SIZE_DEF
) (
  input  wlm_pkg::sample_t win [WINDOW_SIZE][WINDOW_SIZE],
  input  wlm_pkg::sample_t threshold,
  input  wlm_pkg::sample_t ignore_value,
  output logic             peak
);
  import wlm_pkg::*;

  localparam int CTR = WINDOW_SIZE / 2;
  localparam int CTR_IDX = CTR * WINDOW_SIZE + CTR;

  sample_t centre;
  logic [WINDOW_SIZE*WINDOW_SIZE-1:0] ok;

  assign centre = win[CTR][CTR];

  // Scan order runs over position first, then strip age.
  // Earlier samples must be strictly smaller, later ones no larger.
  always_comb begin
    for (int s = 0; s < WINDOW_SIZE; s++) begin
      for (int p = 0; p < WINDOW_SIZE; p++) begin
        if (p * WINDOW_SIZE + s < CTR_IDX) begin
          ok[p*WINDOW_SIZE+s] = (win[s][p] == ignore_value) || (win[s][p] < threshold) ||
                                (win[s][p] < centre);
        end else if (p * WINDOW_SIZE + s > CTR_IDX) begin
          ok[p*WINDOW_SIZE+s] = (win[s][p] == ignore_value) || (win[s][p] < threshold) ||
                                (win[s][p] <= centre);
        end else begin
          ok[p*WINDOW_SIZE+s] = 1'b1;
        end
      end
    end
  end

  assign peak = (centre != ignore_value) && (centre >= threshold) && (&ok);

endmodule

// ===== rtl/core/window_local_maximum_core.sv =====
// Top level of the streaming window local-maximum core.
// Instantiates the chain of wlm_cell strips and the wlm_peak test; uses wlm_pkg.
`timescale 1ns / 1ps

// Each input word carries one new strip of three signed samples and a line-start
// flag in tuser. The core keeps the WINDOW_SIZE-1 previous strips in a chain of
// cells, tests whether the window centre is the first largest valid sample, and
// returns exactly one output word per input word: the centre value with is_peak
// set, or the ignore value. One word is taken every clock cycle unless a result
// waits on out_tready; each result is in the single output register in the cycle
// after acceptance, behind the combinational compare of all window samples.
// Threshold, ignore value: APB port addresses 0 and 4, written only while the core is idle (not enforced).

module window_local_maximum_core #(
  parameter int WINDOW_SIZE = wlm_pkg::WINDOW_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // strip_top [31:0], strip_mid [63:32], strip_bottom [95:64]
  input  logic [3*wlm_pkg::SAMPLE_W-1:0]   in_tdata,
  // line_start [0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result_value [31:0]
  output logic [wlm_pkg::SAMPLE_W-1:0]     out_tdata,
  // is_peak [0]
  output logic                             out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [wlm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [wlm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [wlm_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import wlm_pkg::*;

  localparam int STORED = WINDOW_SIZE - 1;

  sample_t    threshold_r;
  sample_t    ignore_r;
  logic       cfg_wr;
  reg_idx_t   cfg_sel;

  logic       in_fire;
  cell_ctrl_t ctrl;
  sample_t    new_strip [WINDOW_SIZE];
  sample_t    win       [WINDOW_SIZE][WINDOW_SIZE];
  logic       peak;

  logic       out_valid_r;
  sample_t    out_value_r;
  logic       out_peak_r;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_sel    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_sel)
      REG_THRESHOLD: cfg_prdata = threshold_r;
      REG_IGNORE:    cfg_prdata = ignore_r;
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= SAMPLE_MIN;
      ignore_r    <= SAMPLE_MIN;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_THRESHOLD: threshold_r <= sample_t'(cfg_pwdata);
        REG_IGNORE:    ignore_r    <= sample_t'(cfg_pwdata);
        default:       threshold_r <= threshold_r;
      endcase
    end
  end

  // Strip chain
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign ctrl.load  = in_fire;
  assign ctrl.clear = in_tuser;

  always_comb begin
    for (int p = 0; p < WINDOW_SIZE; p++) begin
      if (p < STRIP_IN) begin
        new_strip[p] = sample_t'(in_tdata[p*SAMPLE_W +: SAMPLE_W]);
      end else begin
        new_strip[p] = ignore_r;
      end
    end
  end

  assign win[STORED] = new_strip;

  for (genvar s = 0; s < STORED; s++) begin : g_cell
    wlm_cell #(
      .WINDOW_SIZE(WINDOW_SIZE)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .ignore_value(ignore_r),
      .strip_in    (win[s+1]),
      .strip_out   (win[s])
    );
  end

  wlm_peak #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_peak (
    .win         (win),
    .threshold   (threshold_r),
    .ignore_value(ignore_r),
    .peak        (peak)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_value_r <= peak ? win[WINDOW_SIZE/2][WINDOW_SIZE/2] : ignore_r;
      out_peak_r  <= peak;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_peak_r;

  // Assertions
  a_peak_not_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (sample_t'(out_tdata) != ignore_r))
    else $error("peak result equals the ignore value");

  a_peak_above_thr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (sample_t'(out_tdata) >= threshold_r))
    else $error("peak result below threshold");

  a_fire_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted word produced no result");

endmodule
